// ===== rtl/imdu_pkg.sv =====
// ----------------------------------------------------------------------------
// imdu_pkg
// Shared opcodes, widths and queue entry type of the integer mul/div unit.
// ----------------------------------------------------------------------------
package imdu_pkg;

  localparam int unsigned XLEN   = 64;
  localparam int unsigned FUNC_W = 4;

  typedef enum logic [FUNC_W-1:0] {
    FN_MUL   = 4'd0,  FN_MULU  = 4'd1,  FN_MULW  = 4'd2,  FN_MULUW = 4'd3,
    FN_MADD  = 4'd4,  FN_MADDW = 4'd5,  FN_MIADD = 4'd6,  FN_MISUB = 4'd7,
    FN_DIV   = 4'd8,  FN_DIVU  = 4'd9,  FN_DIVW  = 4'd10, FN_DIVUW = 4'd11,
    FN_REM   = 4'd12, FN_REMU  = 4'd13, FN_REMW  = 4'd14, FN_REMUW = 4'd15
  } func_e;

  // Classified operation as it travels from front to back.
  typedef struct packed {
    logic            is_div;   // divide/remainder path
    logic            is_rem;   // return remainder
    logic            is_word;  // 32-bit form
    logic            is_sgn;   // signed divide / sign-extended result
    logic            is_acc;   // add src_c
    logic            is_sub;   // subtract src_c
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] c;
  } op_t;

endpackage

// ===== rtl/imdu_front.sv =====
// ----------------------------------------------------------------------------
// imdu_front
// Decode func and prepare word-divide operands; registered into a 2-entry queue.
// ----------------------------------------------------------------------------
module imdu_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [imdu_pkg::FUNC_W-1:0] func_i,
  input  logic [imdu_pkg::XLEN-1:0]   src_a_i,
  input  logic [imdu_pkg::XLEN-1:0]   src_b_i,
  input  logic [imdu_pkg::XLEN-1:0]   src_c_i,
  output logic                        q_valid_o,
  input  logic                        q_ready_i,
  output imdu_pkg::op_t               q_op_o
);
  import imdu_pkg::*;

  op_t        dec;
  func_e      fn;
  op_t        ent_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, wr_d, rd_q, rd_d;
  logic       push, pop;

  // Classify the opcode
  always_comb begin
    fn          = func_e'(func_i);
    dec         = '0;
    dec.is_div  = func_i[3];
    dec.is_rem  = func_i[3] & func_i[2];
    dec.is_word = func_i[3] ? func_i[1] : (fn == FN_MULW || fn == FN_MULUW || fn == FN_MADDW);
    dec.is_sgn  = func_i[3] ? ~func_i[0] : (fn == FN_MULW || fn == FN_MADDW);
    dec.is_acc  = (fn == FN_MADD || fn == FN_MADDW || fn == FN_MIADD);
    dec.is_sub  = (fn == FN_MISUB);
    dec.a       = src_a_i;
    dec.b       = src_b_i;
    dec.c       = src_c_i;
    // Word divides: extend low halves by signedness
    if (func_i[3] && func_i[1]) begin
      dec.a = {{32{~func_i[0] & src_a_i[31]}}, src_a_i[31:0]};
      dec.b = {{32{~func_i[0] & src_b_i[31]}}, src_b_i[31:0]};
    end
  end

  assign ready_o   = (cnt_q != 2'd2);
  assign push      = valid_i & ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_valid_o & q_ready_i;
  assign q_op_o    = ent_q[rd_q];

  always_comb begin
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
    wr_d  = wr_q ^ push;
    rd_d  = rd_q ^ pop;
  end

  // Advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      wr_q  <= wr_d;
      rd_q  <= rd_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= dec;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
    else $error("full queue lost an entry");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop)
    else $error("pop from empty queue");

endmodule

// ===== rtl/imdu_back.sv =====
// ----------------------------------------------------------------------------
// imdu_back
// Pipelined execution: 32x32 partial-product multiply and a radix-2 divider
// unrolled one bit per stage, in-order, with a stall-all valid/ready pipe.
// ----------------------------------------------------------------------------
module imdu_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  output logic                      q_ready_o,
  input  imdu_pkg::op_t             q_op_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [imdu_pkg::XLEN-1:0] result_o
);
  import imdu_pkg::*;

  localparam int unsigned NS = XLEN + 3;  // prep, 64 div steps, fixup, result

  typedef struct packed {
    logic            is_div, is_rem, is_word, is_sgn, is_acc, is_sub;
    logic            neg_q, neg_r, dz;
    logic [XLEN-1:0] a, b, c;     // a/b: magnitudes (div) or operands (mul)
    logic [XLEN-1:0] rem, quo;    // quo: dividend shifts out, quotient in; rem: raw dividend
    logic [XLEN-1:0] p;           // product partial sum, divide partial remainder, result
  } st_t;

  st_t        s_q [NS];
  st_t        s_d [NS];
  logic [NS-1:0] v_q;
  logic       adv;

  // Whole pipe moves together when output slot is free
  assign adv       = !v_q[NS-1] || ready_i;
  assign q_ready_o = adv;
  assign valid_o   = v_q[NS-1];
  assign result_o  = s_q[NS-1].p;

  // Stage 0: magnitudes and signs
  always_comb begin
    s_d[0]        = '0;
    s_d[0].is_div = q_op_i.is_div;  s_d[0].is_rem = q_op_i.is_rem;
    s_d[0].is_word = q_op_i.is_word; s_d[0].is_sgn = q_op_i.is_sgn;
    s_d[0].is_acc = q_op_i.is_acc;  s_d[0].is_sub = q_op_i.is_sub;
    s_d[0].c      = q_op_i.c;
    s_d[0].dz     = (q_op_i.b == '0);
    if (q_op_i.is_div && q_op_i.is_sgn) begin
      s_d[0].a     = q_op_i.a[XLEN-1] ? XLEN'(0) - q_op_i.a : q_op_i.a;
      s_d[0].b     = q_op_i.b[XLEN-1] ? XLEN'(0) - q_op_i.b : q_op_i.b;
      s_d[0].neg_q = q_op_i.a[XLEN-1] ^ q_op_i.b[XLEN-1];
      s_d[0].neg_r = q_op_i.a[XLEN-1];
    end else begin
      s_d[0].a = q_op_i.a;
      s_d[0].b = q_op_i.b;
    end
    s_d[0].quo = s_d[0].a;  // dividend shifts out of quo
    s_d[0].rem = q_op_i.a;  // keep raw dividend for zero-divisor case
  end

  // Stages 1..64: divide one bit per stage; multiply uses four of them
  for (genvar k = 1; k <= XLEN; k++) begin : g_step
    always_comb begin
      logic [XLEN:0]   tr;
      logic [XLEN:0]   df;
      logic [XLEN-1:0] pp;
      tr     = '0;
      df     = '0;
      pp     = '0;
      s_d[k] = s_q[k-1];
      if (s_q[k-1].is_div) begin
        // rem field keeps the raw dividend for the fixup; track partial in p
        tr = {s_q[k-1].p, s_q[k-1].quo[XLEN-1]};
        df = tr - {1'b0, s_q[k-1].b};
        s_d[k].quo = {s_q[k-1].quo[XLEN-2:0], ~df[XLEN]};
        s_d[k].p   = df[XLEN] ? tr[XLEN-1:0] : df[XLEN-1:0];
      end else if (k <= 4) begin
        // low 64-bit product: a_lo*b_lo, a_lo*b_hi, a_hi*b_lo, accumulate
        unique case (k)
          1: pp = s_q[k-1].a[31:0] * s_q[k-1].b[31:0];
          2: pp = {s_q[k-1].a[31:0] * s_q[k-1].b[63:32], 32'd0};
          3: pp = {s_q[k-1].a[63:32] * s_q[k-1].b[31:0], 32'd0};
          default: pp = '0;
        endcase
        s_d[k].p = s_q[k-1].p + pp;
      end
    end
  end

  // Fixup stage: signs, special cases, accumulate
  always_comb begin
    logic [XLEN-1:0] q, r, m;
    s_d[XLEN+1] = s_q[XLEN];
    q = s_q[XLEN].neg_q ? XLEN'(0) - s_q[XLEN].quo : s_q[XLEN].quo;
    r = s_q[XLEN].neg_r ? XLEN'(0) - s_q[XLEN].p : s_q[XLEN].p;
    m = s_q[XLEN].is_acc ? s_q[XLEN].p + s_q[XLEN].c :
        s_q[XLEN].is_sub ? s_q[XLEN].p - s_q[XLEN].c : s_q[XLEN].p;
    if (s_q[XLEN].is_div) begin
      if (s_q[XLEN].dz) begin
        s_d[XLEN+1].p = s_q[XLEN].is_rem ? s_q[XLEN].rem : '1;
      end else begin
        s_d[XLEN+1].p = s_q[XLEN].is_rem ? r : q;
      end
    end else begin
      s_d[XLEN+1].p = m;
    end
  end

  // Result stage: word extension
  always_comb begin
    s_d[XLEN+2] = s_q[XLEN+1];
    if (s_q[XLEN+1].is_word) begin
      s_d[XLEN+2].p = {{32{s_q[XLEN+1].is_sgn & s_q[XLEN+1].p[31]}},
                       s_q[XLEN+1].p[31:0]};
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NS-2:0], q_valid_i};
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q[0] <= s_d[0];
      for (int i = 1; i < NS; i++) begin
        s_q[i] <= s_d[i - 1 + 1];
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> valid_o)
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v_q))
    else $error("pipe moved while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid_i && q_ready_o) |=> v_q[0])
    else $error("accepted op not captured");

endmodule

// ===== rtl/integer_mul_div_unit_core.sv =====
// ----------------------------------------------------------------------------
// integer_mul_div_unit_core
// Integer multiply, multiply-add and divide/remainder unit of a 64-bit core.
// ----------------------------------------------------------------------------
// Accepts one operation per cycle while the queue is not full. A front stage decodes
// func into a 2-entry queue; the back end is a 67-stage pipeline (operand prep, 64
// one-bit divide stages that the multiply also flows through, fixup, extension);
// each result is held at the output until it is accepted.
// An output stall freezes the back pipe; the queue holds up to two beats.
module integer_mul_div_unit_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [imdu_pkg::FUNC_W-1:0] func_i,
  input  logic [imdu_pkg::XLEN-1:0]   src_a_i,
  input  logic [imdu_pkg::XLEN-1:0]   src_b_i,
  input  logic [imdu_pkg::XLEN-1:0]   src_c_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [imdu_pkg::XLEN-1:0]   result_o
);
  import imdu_pkg::*;

  logic q_valid, q_ready;
  op_t  q_op;

  imdu_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .func_i, .src_a_i, .src_b_i, .src_c_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_op_o(q_op)
  );

  imdu_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_op_i(q_op),
    .valid_o, .ready_i, .result_o
  );

endmodule
